// ===== rtl/core/mrbm_pkg.sv =====
// Shared types and constants for the maximal rectangle block.
`default_nettype none

package mrbm_pkg;

    localparam int AREA_W = 17;
    localparam logic [AREA_W-1:0] AREA_MAX = 17'h1FFFF;
    localparam int ROW_WIDTH_W = 7;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 7'd8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_LOAD,
        ST_FETCH,
        ST_CMP,
        ST_POP,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/max_rectangle_binary_matrix.sv =====
// Streaming maximal all-ones rectangle over a binary matrix, one cell per transaction.
//
// Cells arrive row-major on the in_valid/in_ready channel (cell_req, final_row).
// row_width, written through cfg_wen/cfg_wdata, sets the columns per row; write it
// only while idle, which the block itself does not enforce. A cell that does not
// close a row takes a height read in IDLE, then a write-back in UPD. The closing
// cell triggers a histogram pass over the column-height RAM using an index stack
// held in a second RAM, the top entry kept in registers. Each column height is
// captured in FETCH and compared in CMP; each stack pop goes through POP to CMP.
// One transaction per row leaves on out_valid/out_ready: row_area, best_area and
// matrix_done. The result sits in an output register, so new cells are taken
// while it waits; only the next row's result stalls behind an untaken one.
// After reset, and after a row flagged final_row, a clearing pass writes zero to
// every height entry while in_ready is low. The running best is cleared after the
// final row's transaction is loaded.
`default_nettype none

module max_rectangle_binary_matrix #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wen,
    input  wire logic [mrbm_pkg::ROW_WIDTH_W-1:0]   cfg_wdata,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               cell_req,
    input  wire logic                               final_row,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [mrbm_pkg::AREA_W-1:0]        row_area,
    output logic      [mrbm_pkg::AREA_W-1:0]        best_area,
    output logic                                    matrix_done
);

    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DW  = $clog2(MAX_COLS + 2);
    localparam int HW  = $clog2(MAX_ROWS + 1);
    localparam int SW  = CW + HW;
    localparam int PW  = HW + CW;
    localparam int EW  = (PW > mrbm_pkg::AREA_W) ? PW : mrbm_pkg::AREA_W;
    localparam int AREA_W = mrbm_pkg::AREA_W;

    mrbm_pkg::state_t state_reg, state_next;

    logic [mrbm_pkg::ROW_WIDTH_W-1:0] rw_reg;
    logic [AW-1:0]     col_reg, col_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [CW-1:0]     top_idx_reg, top_idx_next;
    logic [HW-1:0]     top_h_reg, top_h_next;
    logic [HW-1:0]     hcur_reg, hcur_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic              area_pend_reg, area_pend_next;
    logic [AREA_W-1:0] best_reg, best_next;
    logic [AREA_W-1:0] run_best_reg, run_best_next;
    logic              cell_reg, cell_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic [AREA_W-1:0] row_area_reg, row_area_next;
    logic [AREA_W-1:0] best_area_reg, best_area_next;
    logic              done_reg, done_next;

    logic [CW-1:0]     eff_w;
    logic [CW-1:0]     col_inc;
    logic              push_c;
    logic [HW-1:0]     h_new;
    logic [CW-1:0]     span;
    logic [EW-1:0]     prod;
    logic [AREA_W-1:0] area_sat;
    logic [AREA_W-1:0] best_fold;
    logic [AREA_W-1:0] row_best_total;
    logic              out_load;

    logic              h_we;
    logic [AW-1:0]     h_waddr;
    logic [HW-1:0]     h_wdata;
    logic [AW-1:0]     h_raddr;
    logic [HW-1:0]     h_rdata;

    logic              s_we;
    logic [AW-1:0]     s_waddr;
    logic [SW-1:0]     s_wdata;
    logic [AW-1:0]     s_raddr;
    logic [SW-1:0]     s_rdata;
    logic [CW-1:0]     below_idx;
    logic [HW-1:0]     below_h;

    mrbm_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_COLS)
    ) u_height_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    mrbm_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_COLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign below_idx = s_rdata[SW-1:HW];
    assign below_h   = s_rdata[HW-1:0];

    // Effective row width: zero acts as one, clamp at MAX_COLS
    always_comb
    begin
        if (rw_reg == '0)
        begin
            eff_w = CW'(1);
        end
        else if (int'(rw_reg) > MAX_COLS)
        begin
            eff_w = CW'(MAX_COLS);
        end
        else
        begin
            eff_w = CW'(rw_reg);
        end
    end

    assign col_inc = CW'(col_reg) + CW'(1);
    assign push_c  = (depth_reg == '0) || (top_h_reg < hcur_reg);

    always_comb
    begin
        if (!cell_reg)
        begin
            h_new = '0;
        end
        else if (h_rdata < HW'(MAX_ROWS))
        begin
            h_new = h_rdata + HW'(1);
        end
        else
        begin
            h_new = h_rdata;
        end
    end

    assign span = (depth_reg == DW'(1)) ? i_reg : (i_reg - below_idx - CW'(1));
    assign prod = EW'(top_h_reg) * EW'(span);
    assign area_sat = (prod > EW'(mrbm_pkg::AREA_MAX)) ? mrbm_pkg::AREA_MAX
                                                       : AREA_W'(prod);
    assign best_fold = (area_pend_reg && (area_reg > best_reg)) ? area_reg : best_reg;
    assign row_best_total = (best_reg > run_best_reg) ? best_reg : run_best_reg;
    assign out_load = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrbm_pkg::ST_CLEAR:
            begin
                if (int'(clr_reg) == MAX_COLS - 1)
                begin
                    state_next = mrbm_pkg::ST_IDLE;
                end
            end
            mrbm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mrbm_pkg::ST_UPD;
                end
            end
            mrbm_pkg::ST_UPD:
            begin
                state_next = (col_inc < eff_w) ? mrbm_pkg::ST_IDLE : mrbm_pkg::ST_LOAD;
            end
            mrbm_pkg::ST_LOAD:
            begin
                state_next = mrbm_pkg::ST_FETCH;
            end
            mrbm_pkg::ST_FETCH:
            begin
                state_next = mrbm_pkg::ST_CMP;
            end
            mrbm_pkg::ST_CMP:
            begin
                if (!push_c)
                begin
                    state_next = mrbm_pkg::ST_POP;
                end
                else if (i_reg == eff_w)
                begin
                    state_next = mrbm_pkg::ST_OUT;
                end
                else
                begin
                    state_next = mrbm_pkg::ST_FETCH;
                end
            end
            mrbm_pkg::ST_POP:
            begin
                state_next = mrbm_pkg::ST_CMP;
            end
            mrbm_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = last_reg ? mrbm_pkg::ST_CLEAR : mrbm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrbm_pkg::ST_CLEAR;
            end
        endcase
    end

    // Handshake and memory controls
    always_comb
    begin
        in_ready = 1'b0;
        h_we     = 1'b0;
        h_waddr  = col_reg;
        h_wdata  = h_new;
        h_raddr  = col_reg;
        s_we     = 1'b0;
        s_waddr  = AW'(depth_reg - DW'(1));
        s_wdata  = {top_idx_reg, top_h_reg};
        s_raddr  = AW'(depth_reg - DW'(2));
        unique case (state_reg)
            mrbm_pkg::ST_CLEAR:
            begin
                h_we    = 1'b1;
                h_waddr = clr_reg;
                h_wdata = '0;
            end
            mrbm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            mrbm_pkg::ST_UPD:
            begin
                h_we = 1'b1;
            end
            mrbm_pkg::ST_LOAD:
            begin
                h_raddr = '0;
            end
            mrbm_pkg::ST_CMP:
            begin
                h_raddr = AW'(i_reg + CW'(1));
                s_we    = push_c && (depth_reg != '0);
            end
            mrbm_pkg::ST_FETCH,
            mrbm_pkg::ST_POP,
            mrbm_pkg::ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        col_next       = col_reg;
        clr_next       = clr_reg;
        i_next         = i_reg;
        depth_next     = depth_reg;
        top_idx_next   = top_idx_reg;
        top_h_next     = top_h_reg;
        hcur_next      = hcur_reg;
        area_next      = area_reg;
        area_pend_next = area_pend_reg;
        best_next      = best_reg;
        run_best_next  = run_best_reg;
        cell_next      = cell_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        row_area_next  = row_area_reg;
        best_area_next = best_area_reg;
        done_next      = done_reg;
        unique case (state_reg)
            mrbm_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            mrbm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cell_next = cell_req;
                    last_next = final_row;
                end
            end
            mrbm_pkg::ST_UPD:
            begin
                if (col_inc < eff_w)
                begin
                    col_next = AW'(col_inc);
                end
                else
                begin
                    col_next       = '0;
                    i_next         = '0;
                    depth_next     = '0;
                    best_next      = '0;
                    area_pend_next = 1'b0;
                end
            end
            mrbm_pkg::ST_FETCH:
            begin
                hcur_next = (i_reg < eff_w) ? h_rdata : '0;
            end
            mrbm_pkg::ST_CMP:
            begin
                best_next      = best_fold;
                area_pend_next = 1'b0;
                if (push_c)
                begin
                    top_idx_next = i_reg;
                    top_h_next   = hcur_reg;
                    depth_next   = depth_reg + DW'(1);
                    i_next       = i_reg + CW'(1);
                end
            end
            mrbm_pkg::ST_POP:
            begin
                area_next      = area_sat;
                area_pend_next = 1'b1;
                depth_next     = depth_reg - DW'(1);
                if (depth_reg != DW'(1))
                begin
                    top_idx_next = below_idx;
                    top_h_next   = below_h;
                end
            end
            mrbm_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    row_area_next  = best_reg;
                    best_area_next = row_best_total;
                    done_next      = last_reg;
                    run_best_next  = last_reg ? '0 : row_best_total;
                    clr_next       = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrbm_pkg::ST_CLEAR;
            rw_reg        <= mrbm_pkg::ROW_WIDTH_RST;
            col_reg       <= '0;
            clr_reg       <= '0;
            i_reg         <= '0;
            depth_reg     <= '0;
            area_pend_reg <= 1'b0;
            best_reg      <= '0;
            run_best_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wen)
            begin
                rw_reg <= cfg_wdata;
            end
            col_reg       <= col_next;
            clr_reg       <= clr_next;
            i_reg         <= i_next;
            depth_reg     <= depth_next;
            area_pend_reg <= area_pend_next;
            best_reg      <= best_next;
            run_best_reg  <= run_best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_idx_reg   <= top_idx_next;
        top_h_reg     <= top_h_next;
        hcur_reg      <= hcur_next;
        area_reg      <= area_next;
        cell_reg      <= cell_next;
        last_reg      <= last_next;
        row_area_reg  <= row_area_next;
        best_area_reg <= best_area_next;
        done_reg      <= done_next;
    end

    assign out_valid   = out_valid_reg;
    assign row_area    = row_area_reg;
    assign best_area   = best_area_reg;
    assign matrix_done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mrbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mrbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
